// ===== rtl/dlx_pkg.sv =====
package dlx_pkg;

  // Byte and length field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;

  // Framing symbols
  localparam logic [BYTE_W-1:0] SYM_DLE = 8'h10;
  localparam logic [BYTE_W-1:0] SYM_ETX = 8'h03;

endpackage

// ===== rtl/dlx_ram.sv =====
module dlx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dlx_parser.sv =====
module dlx_parser #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [dlx_pkg::BYTE_W-1:0]       rx_byte,
  output logic                             mem_we,
  output logic [$clog2(BUF_DEPTH)-1:0]     mem_waddr,
  output logic [dlx_pkg::BYTE_W-1:0]       mem_wdata,
  output logic                             close_start,
  output logic [$clog2(BUF_DEPTH+1)-1:0]   close_count,
  output logic [dlx_pkg::LEN_W-1:0]        close_length
);

  import dlx_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_DLE_ETX = 3'd1,
    ST_ETX     = 3'd2,
    ST_DLE     = 3'd3,
    ST_ID      = 3'd4,
    ST_MSG     = 3'd5
  } state_t;

  state_t              state_r, state_nxt, state_eff;
  logic                stuffed_r, stuffed_nxt;
  logic [CW-1:0]       count_r, count_nxt, count_eff;
  logic [BYTE_W-1:0]   last_r, last_nxt;
  logic                put;
  logic [CW-1:0]       put_idx;
  logic [BYTE_W-1:0]   put_data;
  logic [CW-1:0]       len;
  logic                is_dle, is_etx, end_seq;

  assign is_dle = (rx_byte == SYM_DLE);
  assign is_etx = (rx_byte == SYM_ETX);

  // Drop a full frame before handling the byte
  always_comb begin
    state_eff = state_r;
    count_eff = count_r;
    if (count_r >= DEPTH_C) begin
      state_eff = ST_START;
      count_eff = '0;
    end
  end

  assign end_seq = (last_r == SYM_DLE) && !stuffed_r;
  assign len     = (count_eff >= CW'(2)) ? count_eff - CW'(2) : '0;

  // Advance the receiver by one byte
  always_comb begin
    state_nxt   = state_eff;
    stuffed_nxt = stuffed_r;
    count_nxt   = count_eff;
    last_nxt    = last_r;
    put         = 1'b0;
    put_idx     = count_eff;
    put_data    = rx_byte;
    close_start = 1'b0;
    case (state_eff)
      ST_START: begin
        if (is_dle) begin
          put       = 1'b1;
          put_idx   = '0;
          put_data  = SYM_DLE;
          state_nxt = ST_ID;
        end else if (!is_etx) begin
          state_nxt = ST_DLE_ETX;
          count_nxt = '0;
        end
        stuffed_nxt = 1'b0;
      end
      ST_DLE_ETX: state_nxt = is_dle ? ST_ETX : ST_START;
      ST_ETX:     state_nxt = is_etx ? ST_DLE : ST_START;
      ST_DLE: begin
        if (is_dle) begin
          put       = 1'b1;
          put_idx   = '0;
          put_data  = SYM_DLE;
          state_nxt = ST_ID;
        end else begin
          state_nxt = ST_START;
        end
        stuffed_nxt = 1'b0;
      end
      ST_ID: begin
        if (is_dle || is_etx) begin
          state_nxt = ST_START;
          count_nxt = '0;
        end else begin
          state_nxt = ST_MSG;
          put       = 1'b1;
        end
      end
      ST_MSG: begin
        if (is_dle && end_seq) begin
          stuffed_nxt = 1'b1;
        end else if (is_etx && end_seq) begin
          close_start = accept && (len != '0);
          state_nxt   = ST_DLE;
        end else begin
          put         = 1'b1;
          stuffed_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_START;
    endcase
    if (put) begin
      count_nxt = put_idx + CW'(1);
      last_nxt  = put_data;
    end
  end

  assign mem_we       = accept && put;
  assign mem_waddr    = put_idx[AW-1:0];
  assign mem_wdata    = put_data;
  assign close_count  = len;
  assign close_length = LEN_W'(len);

  // Hold receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_START;
      stuffed_r <= 1'b0;
      count_r   <= '0;
      last_r    <= '0;
    end else if (accept) begin
      state_r   <= state_nxt;
      stuffed_r <= stuffed_nxt;
      count_r   <= count_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

// ===== rtl/dlx_drain.sv =====
module dlx_drain #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [$clog2(BUF_DEPTH+1)-1:0]   count,
  input  logic [dlx_pkg::LEN_W-1:0]        length,
  output logic                             busy,
  output logic [$clog2(BUF_DEPTH)-1:0]     mem_raddr,
  input  logic [dlx_pkg::BYTE_W-1:0]       mem_rdata,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dlx_pkg::BYTE_W-1:0]       out_frame_byte,
  output logic [dlx_pkg::LEN_W-1:0]        out_frame_length,
  output logic                             out_last_byte
);

  import dlx_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic [CW-1:0]     left_r;
  logic [AW-1:0]     rd_addr_r;
  logic [LEN_W-1:0]  len_r;
  logic              pend_r, pend_last_r;
  logic              out_valid_r, out_last_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              take, issue;

  assign take  = out_valid_r && !out_stall;
  assign issue = (left_r != '0) && !pend_r && (!out_valid_r || take);
  assign busy  = (left_r != '0) || pend_r;
  assign mem_raddr = rd_addr_r;

  // Issue one store read per item, load the output register when data returns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        left_r    <= count;
        rd_addr_r <= AW'(1);
        len_r     <= length;
      end else if (issue) begin
        left_r    <= left_r - CW'(1);
        rd_addr_r <= rd_addr_r + AW'(1);
      end
      pend_r <= issue;
      if (issue) begin
        pend_last_r <= (left_r == CW'(1));
      end
      if (pend_r) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= mem_rdata;
        out_last_r  <= pend_last_r;
        out_len_r   <= len_r;
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_byte_r;
  assign out_frame_length = out_len_r;
  assign out_last_byte    = out_last_r;

`ifndef NO_ASSERTIONS
  // A new frame only starts once the previous run is fully read
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (left_r == '0) && !pend_r)
    else $error("frame closed while a run is still being read");

  // Returning read data always finds the output register free
  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r)
    else $error("read data returned into an occupied output register");

  // Returning read data shows up as an item
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("read data lost");
`endif

endmodule

// ===== rtl/dle_etx_frame_receiver_top.sv =====
// DLE/ETX frame receiver: one received byte per item, unstuffed frame out as a run.
// A closing ETX starts the run: each item is read from the store, then registered out.
// Throughput: one input item per cycle unless stalled; a run drains one item at a time
// (store read, then output register), and input stalls until the last read returns.
// Reset (rst_n low, synchronous) returns the receiver to hunting and empties the output;
// the frame store needs no clearing.
module dle_etx_frame_receiver_top #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dlx_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dlx_pkg::BYTE_W-1:0] out_frame_byte,
  output logic [dlx_pkg::LEN_W-1:0]  out_frame_length,
  output logic                       out_last_byte
);

  import dlx_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic              accept;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  logic              close_start;
  logic [CW-1:0]     close_count;
  logic [LEN_W-1:0]  close_length;
  logic              drain_busy;

  // Stall input while a run is being read out
  assign in_stall = drain_busy;
  assign accept   = in_valid && !drain_busy;

  dlx_parser #(.BUF_DEPTH(BUF_DEPTH)) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .rx_byte      (in_rx_byte),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .close_start  (close_start),
    .close_count  (close_count),
    .close_length (close_length)
  );

  dlx_ram #(.WIDTH(BYTE_W), .DEPTH(BUF_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dlx_drain #(.BUF_DEPTH(BUF_DEPTH)) u_drain (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (close_start),
    .count            (close_count),
    .length           (close_length),
    .busy             (drain_busy),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_last_byte    (out_last_byte)
  );

endmodule

// ===== sim/dle_frame_checker.sv =====
module dle_frame_checker #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [dlx_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [dlx_pkg::BYTE_W-1:0] out_frame_byte,
  input  logic [dlx_pkg::LEN_W-1:0]  out_frame_length,
  input  logic                       out_last_byte,
  output int                         mismatches,
  output int                         pending
);
  import dlx_pkg::*;

  // Receiver phases, in the order of their state codes
  typedef enum logic [2:0] {
    HUNT, SEEK_DLE, SEEK_ETX, SEEK_OPEN, SEEK_ID, IN_MSG
  } rx_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] fbyte;
    logic [LEN_W-1:0]  flen;
    logic              fin;
  } frame_item_t;

  rx_phase_t         phase;
  logic              doubled;
  int unsigned       held;
  logic [BYTE_W-1:0] prev_kept;
  logic [BYTE_W-1:0] kept [DEPTH];
  frame_item_t       frame_items_due [$];
  int                errs = 0;
  int                due_cnt = 0;

  assign mismatches = errs;
  assign pending    = due_cnt;

  // Store a byte while there is room; always remember it as the latest
  function automatic void keep_byte(input logic [BYTE_W-1:0] b);
    if (held < DEPTH) begin
      kept[held] = b;
      held++;
    end
    prev_kept = b;
  endfunction

  function automatic void open_frame();
    held = 0;
    keep_byte(SYM_DLE);
    phase = SEEK_ID;
  endfunction

  // Advance the receiver by one byte and queue the frame it completes, if any
  function automatic void receive_byte(input logic [BYTE_W-1:0] c);
    int unsigned run_len;
    frame_item_t fi;
    if (held >= DEPTH) begin
      phase = HUNT;
      held  = 0;
    end
    case (phase)
      HUNT: begin
        if (c == SYM_DLE) begin
          open_frame();
        end else if (c != SYM_ETX) begin
          phase = SEEK_DLE;
          held  = 0;
        end
        doubled = 1'b0;
      end
      SEEK_DLE: phase = (c == SYM_DLE) ? SEEK_ETX : HUNT;
      SEEK_ETX: phase = (c == SYM_ETX) ? SEEK_OPEN : HUNT;
      SEEK_OPEN: begin
        if (c == SYM_DLE) open_frame();
        else phase = HUNT;
        doubled = 1'b0;
      end
      SEEK_ID: begin
        if (c == SYM_DLE || c == SYM_ETX) begin
          phase = HUNT;
          held  = 0;
        end else begin
          phase = IN_MSG;
          keep_byte(c);
        end
      end
      IN_MSG: begin
        if (c == SYM_DLE && prev_kept == SYM_DLE && !doubled) begin
          doubled = 1'b1;
        end else if (c == SYM_ETX && prev_kept == SYM_DLE && !doubled) begin
          // store holds opening DLE, ID, payload, closing DLE
          run_len = (held >= 2) ? held - 2 : 0;
          for (int unsigned k = 0; k < run_len; k++) begin
            fi.fbyte = kept[(k + 1) % DEPTH];
            fi.flen  = run_len[LEN_W-1:0];
            fi.fin   = (k + 1 == run_len);
            frame_items_due.push_back(fi);
          end
          phase = SEEK_OPEN;
        end else begin
          keep_byte(c);
          doubled = 1'b0;
        end
      end
      default: phase = HUNT;
    endcase
  endfunction

  // Compare accepted results, then predict from accepted input bytes
  always @(posedge clk) begin
    frame_item_t want;
    if (!rst_n) begin
      phase     = HUNT;
      doubled   = 1'b0;
      held      = 0;
      prev_kept = '0;
      frame_items_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_items_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected item: expected none, got byte %h length %0d last %0b",
                   $time, out_frame_byte, out_frame_length, out_last_byte);
        end else begin
          want = frame_items_due.pop_front();
          if (out_frame_byte !== want.fbyte) begin
            errs++;
            $display("%0t: frame_byte mismatch: expected %h, got %h",
                     $time, want.fbyte, out_frame_byte);
          end
          if (out_frame_length !== want.flen) begin
            errs++;
            $display("%0t: frame_length mismatch: expected %0d, got %0d",
                     $time, want.flen, out_frame_length);
          end
          if (out_last_byte !== want.fin) begin
            errs++;
            $display("%0t: last_byte mismatch: expected %0b, got %0b",
                     $time, want.fin, out_last_byte);
          end
        end
      end
      if (in_valid && !in_stall) receive_byte(in_rx_byte);
    end
    due_cnt = frame_items_due.size();
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import dlx_pkg::*;

  localparam int DEPTH     = 64;
  localparam int ITEM_GOAL = 410;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_frame_byte;
  logic [LEN_W-1:0]  out_frame_length;
  logic              out_last_byte;
  int                mismatches;
  int                pending;

  int                bytes_sent    = 0;
  int                results_taken = 0;
  int                tx_left       = 0;
  bit                tx_eager      = 1'b0;
  int                rx_left       = 0;
  bit                rx_eager      = 1'b0;

  // Directed bytes: hunting, end-sequence sync, stuffing, empty frame,
  // bad IDs and a lone DLE inside a frame
  logic [BYTE_W-1:0] lead_in [25] = '{
    8'h03,
    8'hFF, SYM_DLE, SYM_ETX,
    SYM_DLE, 8'h00, 8'hFF, SYM_DLE, SYM_DLE, SYM_DLE, SYM_ETX,
    SYM_DLE, 8'h7F, SYM_DLE, SYM_ETX,
    SYM_DLE, SYM_DLE,
    SYM_DLE, SYM_ETX,
    SYM_DLE, 8'h80, SYM_DLE, 8'h55, SYM_DLE, SYM_ETX
  };

  dle_etx_frame_receiver_top #(.BUF_DEPTH(DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_last_byte    (out_last_byte)
  );

  dle_frame_checker #(.DEPTH(DEPTH)) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_last_byte    (out_last_byte),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always #10 clk = ~clk;

  // Wait before the next item; each stretch is at random either gap-free or idling
  function automatic int draw_gap(inout int left, inout bit eager);
    if (left == 0) begin
      left  = $urandom_range(8, 40);
      eager = ($urandom_range(0, 2) == 0);
    end
    left--;
    return eager ? 0 : $urandom_range(0, 9);
  endfunction

  // Random byte, leaning toward the framing symbols
  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return SYM_DLE;
      1:       return SYM_ETX;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_id();
    logic [BYTE_W-1:0] id;
    do id = BYTE_W'($urandom_range(0, 255));
    while (id == SYM_DLE || id == SYM_ETX);
    return id;
  endfunction

  // Offer one byte and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = draw_gap(tx_left, tx_eager);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Well-formed frame: DLE, ID, stuffed payload, DLE, ETX
  task automatic send_frame(input int payload_len);
    logic [BYTE_W-1:0] b;
    send_byte(SYM_DLE);
    send_byte(rand_id());
    for (int i = 0; i < payload_len; i++) begin
      b = rand_byte();
      send_byte(b);
      if (b == SYM_DLE) send_byte(SYM_DLE);
    end
    send_byte(SYM_DLE);
    send_byte(SYM_ETX);
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the input
  initial begin
    int  gap;
    bit  held_off;
    held_off  = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_off && results_taken == 30) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      gap = draw_gap(rx_left, rx_eager);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    int n;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (lead_in[i]) send_byte(lead_in[i]);

    while (bytes_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: begin
          // line noise
          n = $urandom_range(1, 4);
          repeat (n) send_byte(rand_byte());
        end
        1: begin
          // bad ID or a frame cut short
          send_byte(SYM_DLE);
          if ($urandom_range(0, 1) == 0) begin
            send_byte(($urandom_range(0, 1) == 0) ? SYM_DLE : SYM_ETX);
          end else begin
            send_byte(rand_id());
            n = $urandom_range(1, 5);
            repeat (n) send_byte(rand_byte());
          end
        end
        default: begin
          // mostly short frames; now and then one near or past the store size
          if ($urandom_range(0, 15) == 0) send_frame($urandom_range(55, 70));
          else send_frame($urandom_range(0, 12));
        end
      endcase
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow for late extras
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("dle_etx_frame_receiver_top verification clean");
    end else begin
      $display("dle_etx_frame_receiver_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("dle_etx_frame_receiver_top verification failed");
    $finish;
  end

endmodule

// ===== dle_etx_frame_receiver_top.f =====
rtl/dlx_pkg.sv
rtl/dlx_ram.sv
rtl/dlx_parser.sv
rtl/dlx_drain.sv
rtl/dle_etx_frame_receiver_top.sv
sim/dle_frame_checker.sv
sim/testbench.sv
